FILE: rtl/core/sobel_pkg.sv
// Package for the Sobel gradient block: widths, constants, controller state type
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package sobel_pkg;
	localparam int MaxLine     = 1024;
	localparam int AddrW       = $clog2(MaxLine);
	localparam int ColW        = AddrW + 1;
	localparam int WidthW      = 11;
	localparam int HeightW     = 12;
	localparam int PixW        = 8;
	localparam int MagW        = 11;
	localparam int SqW         = 22;
	localparam int GradW       = 11;
	localparam int AbsW        = 10;
	localparam int SqrtSteps   = SqW / 2;
	localparam int StepW       = $clog2(SqrtSteps + 1);
	localparam logic [17:0] TanLoQ16 = 18'd27146;
	localparam logic [17:0] TanHiQ16 = 18'd158218;
	localparam logic [WidthW-1:0]  WidthReset  = 11'd640;
	localparam logic [HeightW-1:0] HeightReset = 12'd480;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_0   = 2'd0,
		DIR_45  = 2'd1,
		DIR_90  = 2'd2,
		DIR_135 = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WINDOW,
		ST_ROOT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_mem;
		logic shift_win;
		logic root_start;
		logic root_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic interior;
		logic root_done;
	} status_t;
endpackage
`default_nettype wire

FILE: rtl/core/sobel_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sobel_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/sobel_ctrl.sv
// Controller for the Sobel block: handshake, item sequencing, square root steps.
// Depends on sobel_pkg.
`default_nettype none
module sobel_ctrl import sobel_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t sts,
	output cmd_t         cmd
);
	state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_mem = 1'b1;
					state_d      = ST_WINDOW;
				end
			end
			ST_WINDOW: begin
				cmd.shift_win = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				if (!sts.interior) begin
					state_d = ST_IDLE;
				end else if (sts.root_done) begin
					state_d = ST_OUT;
				end else begin
					cmd.root_step = 1'b1;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.root_start = cmd.shift_win;
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_mem |-> state_q == ST_IDLE)
		else $error("pixel taken while busy");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not shown");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/sobel_dp.sv
// Datapath for the Sobel block: counters, line stores, window, gradients,
// direction and a bit-serial square root. Depends on sobel_pkg and sobel_ram.
`default_nettype none
module sobel_dp import sobel_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output status_t                  sts,
	input  wire logic [PixW-1:0]     pixel_value,
	input  wire logic [WidthW-1:0]   width_q,
	input  wire logic [HeightW-1:0]  height_q,
	output logic      [MagW-1:0]     magnitude,
	output logic      [1:0]          direction_code,
	output logic                     last_of_frame
);
	logic [ColW-1:0]    col_q;
	logic [HeightW-1:0] row_q;
	logic [ColW-1:0]    w_eff;
	logic [HeightW-1:0] h_eff;
	logic               row_end, frame_end;
	logic [PixW-1:0]    pix_q;
	logic [PixW-1:0]    up_rd, mid_rd;
	logic [PixW-1:0]    win_q [9];
	logic               interior_q, last_q;
	logic [AddrW-1:0]   addr;

	always_comb begin
		if (width_q < WidthW'(3)) w_eff = ColW'(3);
		else if (width_q > WidthW'(MaxLine)) w_eff = ColW'(MaxLine);
		else w_eff = ColW'(width_q);
		h_eff = (height_q < HeightW'(3)) ? HeightW'(3) : height_q;
	end

	assign row_end   = (ColW'(col_q + ColW'(1)) >= w_eff) || (col_q == '1);
	assign frame_end = row_end &&
		((HeightW+1)'(row_q) + (HeightW+1)'(1) >= (HeightW+1)'(h_eff));
	assign addr      = col_q[AddrW-1:0];

	sobel_ram #(.Width(PixW), .Depth(MaxLine)) u_upper (
		.clk(clk), .we(cmd.load_mem), .addr(addr), .wdata(mid_rd), .rdata(up_rd));

	// middle store: read old value, write new pixel; the registered read gives the old value
	logic [PixW-1:0] mid_old;
	sobel_ram #(.Width(PixW), .Depth(MaxLine)) u_middle (
		.clk(clk), .we(cmd.load_mem), .addr(addr), .wdata(pixel_value),
		.rdata(mid_old));
	assign mid_rd = mid_old;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			interior_q <= 1'b0;
			last_q     <= 1'b0;
		end else if (cmd.load_mem) begin
			interior_q <= (row_q >= HeightW'(2)) && (col_q >= ColW'(2));
			last_q     <= frame_end;
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : HeightW'(row_q + HeightW'(1));
			end else begin
				col_q <= ColW'(col_q + ColW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_mem) begin
			pix_q <= pixel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (cmd.shift_win) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3+0] <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= up_rd;
			win_q[5] <= mid_old;
			win_q[8] <= pix_q;
		end
	end

	// gradients from the window after the shift (shift is in ST_WINDOW)
	logic signed [GradW-1:0] gx, gy, gx_q, gy_q;
	always_comb begin
		gx = (GradW'(win_q[2]) + GradW'({win_q[5], 1'b0}) + GradW'(win_q[8]))
		   - (GradW'(win_q[0]) + GradW'({win_q[3], 1'b0}) + GradW'(win_q[6]));
		gy = (GradW'(win_q[0]) + GradW'({win_q[1], 1'b0}) + GradW'(win_q[2]))
		   - (GradW'(win_q[6]) + GradW'({win_q[7], 1'b0}) + GradW'(win_q[8]));
	end

	// root/direction state; starts the cycle after the shift
	logic               start_s1;
	logic [AbsW-1:0]    ax_q, ay_q;
	logic [SqW-1:0]     rem_q;
	logic [SqW-1:0]     res_q;
	logic [StepW-1:0]   step_q;
	logic [1:0]         dir_c;
	logic [AbsW-1:0]    ax_c, ay_c;
	logic [33:0]        lhs, lo_r, hi_r;

	assign ax_c = gx[GradW-1] ? AbsW'(-gx) : AbsW'(gx);
	assign ay_c = gy[GradW-1] ? AbsW'(-gy) : AbsW'(gy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_s1 <= 1'b0;
		else start_s1 <= cmd.root_start;
	end

	assign lhs  = {8'd0, ay_q, 16'd0};
	assign lo_r = 34'(ax_q) * 34'(TanLoQ16);
	assign hi_r = 34'(ax_q) * 34'(TanHiQ16);

	logic [SqW-1:0] trial, bit_v;
	assign bit_v = SqW'(1) << {step_q, 1'b0};
	assign trial = res_q + bit_v;

	always_ff @(posedge clk) begin
		if (start_s1) begin
			ax_q   <= ax_c;
			ay_q   <= ay_c;
			gx_q   <= gx;
			gy_q   <= gy;
			rem_q  <= SqW'(ax_c) * SqW'(ax_c) + SqW'(ay_c) * SqW'(ay_c);
			res_q  <= '0;
			step_q <= StepW'(SqrtSteps - 1);
		end else if (cmd.root_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_v;
			end else begin
				res_q <= res_q >> 1;
			end
			step_q <= step_q - StepW'(1);
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else if (start_s1) done_q <= 1'b0;
		else if (cmd.root_step && step_q == '0) done_q <= 1'b1;
	end

	always_comb begin
		if (lhs <= lo_r) dir_c = DIR_0;
		else if (lhs > hi_r) dir_c = DIR_90;
		else if ((gx_q > 0) == (gy_q > 0)) dir_c = DIR_45;
		else dir_c = DIR_135;
	end

	assign sts.interior  = interior_q;
	assign sts.root_done = done_q && !start_s1 && !cmd.root_start;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			magnitude      <= MagW'(res_q);
			direction_code <= dir_c;
			last_of_frame  <= last_q;
		end
	end

`ifndef SYNTH
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= ColW'(MaxLine))
		else $error("column out of range");
	a_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_step && !start_s1 && step_q == '0 |=> done_q)
		else $error("root not finished");
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_mem && frame_end |=> row_q == '0 && col_q == '0)
		else $error("frame did not wrap");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/sobel_gradient_direction_top.sv
// Top level of the Sobel gradient block: configuration registers, controller
// and datapath. Depends on sobel_pkg, sobel_ctrl, sobel_dp.
//
// Pixels arrive on in_valid/in_ready in raster order, one transfer each.
// Every pixel whose window centre is interior yields one result transfer on
// out_valid/out_ready: magnitude, direction_code and last_of_frame.
// An interior pixel passes through load and line store read, window shift,
// operand setup, eleven steps of the bit-serial square root, completion
// check and output load. A border pixel ends after load, window shift and the
// interior check. The square root unit, one result bit a cycle, sets the rate.
// The output register lets a stalled receiver hold the last result while the
// next pixel is worked on; the block waits only when a new result is ready
// and the previous one has not been taken.
// Configuration writes on cfg_valid/cfg_ready (index 0 width, 1 height) are
// always accepted and must only be made while idle.
// Reset clears counters, window and handshake state and restores width 640
// and height 480. Line stores are not cleared.
`default_nettype none
module sobel_gradient_direction_top import sobel_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PixW-1:0]    pixel_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [MagW-1:0]    magnitude,
	output logic      [1:0]         direction_code,
	output logic                    last_of_frame,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [HeightW-1:0] cfg_data
);
	logic [WidthW-1:0]  width_q;
	logic [HeightW-1:0] height_q;
	cmd_t               cmd;
	status_t            sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[WidthW-1:0];
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sobel_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

	sobel_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.pixel_value(pixel_value), .width_q(width_q), .height_q(height_q),
		.magnitude(magnitude), .direction_code(direction_code),
		.last_of_frame(last_of_frame));
endmodule
`default_nettype wire

FILE: sim/sobel_checker.sv
// Checker for the Sobel gradient block: tracks width/height writes and pixel
// transfers, predicts magnitude and direction, compares each result transfer.
// Depends on sobel_pkg.
`timescale 1ns / 1ps
module sobel_checker import sobel_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [PixW-1:0]    pixel_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [MagW-1:0]    magnitude,
	input  logic [1:0]         direction_code,
	input  logic               last_of_frame,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [HeightW-1:0] cfg_data,
	output int                 fail_count,
	output int                 pending
);
	typedef struct {
		logic [MagW-1:0] mag;
		dir_t            dir;
		logic            last;
	} gradient_t;

	gradient_t           grad_q[$];
	logic [WidthW-1:0]   width_reg;
	logic [HeightW-1:0]  height_reg;
	logic [PixW-1:0]     upper_line[MaxLine];
	logic [PixW-1:0]     middle_line[MaxLine];
	logic [PixW-1:0]     win[9];
	logic [AddrW-1:0]    col;
	logic [HeightW-1:0]  row;
	int                  mismatches;

	assign pending = grad_q.size();

	function automatic logic [MagW-1:0] root_floor(int unsigned v);
		int unsigned res, t;
		res = 0;
		for (int b = 10; b >= 0; b--) begin
			t = res | (1 << b);
			if (t * t <= v)
				res = t;
		end
		return res[MagW-1:0];
	endfunction

	function automatic dir_t quantise(int gx, int gy);
		longint ax, ay;
		ax = gx < 0 ? -gx : gx;
		ay = gy < 0 ? -gy : gy;
		if ((ay << 16) <= ax * longint'(TanLoQ16))
			return DIR_0;
		if ((ay << 16) > ax * longint'(TanHiQ16))
			return DIR_90;
		return ((gx > 0) == (gy > 0)) ? DIR_45 : DIR_135;
	endfunction

	task automatic take_pixel(logic [PixW-1:0] p);
		int unsigned w, h;
		int gx, gy;
		logic [PixW-1:0] up, mid;
		logic row_end, frame_end;
		gradient_t g;
		w = width_reg < 3 ? 3 : (width_reg > MaxLine ? MaxLine : width_reg);
		h = height_reg < 3 ? 3 : height_reg;
		up = upper_line[col];
		mid = middle_line[col];
		row_end = (col + 1 >= w);
		frame_end = row_end && (row + 1 >= h);
		upper_line[col] = mid;
		middle_line[col] = p;
		for (int r = 0; r < 3; r++) begin
			win[r*3] = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = up;
		win[5] = mid;
		win[8] = p;
		if (row >= 2 && col >= 2) begin
			gx = (int'(win[2]) + 2*int'(win[5]) + int'(win[8]))
				- (int'(win[0]) + 2*int'(win[3]) + int'(win[6]));
			gy = (int'(win[0]) + 2*int'(win[1]) + int'(win[2]))
				- (int'(win[6]) + 2*int'(win[7]) + int'(win[8]));
			g.mag = root_floor(gx*gx + gy*gy);
			g.dir = quantise(gx, gy);
			g.last = frame_end;
			grad_q.push_back(g);
		end
		if (row_end) begin
			col = '0;
			row = frame_end ? '0 : row + 1'b1;
		end else begin
			col = col + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gradient_t g;
		if (!arst_n) begin
			width_reg = WidthReset;
			height_reg = HeightReset;
			foreach (win[i]) win[i] = '0;
			col = '0;
			row = '0;
			fail_count = 0;
			mismatches = 0;
			grad_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data[WidthW-1:0];
				else
					height_reg = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (grad_q.size() == 0) begin
					fail_count++;
					$display("%0t: result transfer with nothing expected", $realtime);
				end else begin
					g = grad_q.pop_front();
					if (g.mag !== magnitude || g.dir !== direction_code
							|| g.last !== last_of_frame) begin
						fail_count++;
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected mag %0d dir %0d last %0b, got %0d %0d %0b",
								$realtime, g.mag, g.dir, g.last,
								magnitude, direction_code, last_of_frame);
					end
				end
			end
			if (in_valid && in_ready)
				take_pixel(pixel_value);
		end
	end
endmodule

FILE: sim/tb_sobel_gradient_direction_top.sv
// Testbench top for the Sobel gradient block: clock, reset, pixel frames,
// register writes and receiver stalls. Depends on sobel_pkg, sobel_checker.
`timescale 1ns / 1ps
module tb_sobel_gradient_direction_top;
	import sobel_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [PixW-1:0]    pixel_value;
	logic               out_valid;
	logic               out_ready;
	logic [MagW-1:0]    magnitude;
	logic [1:0]         direction_code;
	logic               last_of_frame;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [HeightW-1:0] cfg_data;
	int                 fail_count;
	int                 pending;
	int                 hold_req;
	int                 hold_seen;
	int                 cycles;
	int                 busy_gaps;
	int                 pixels_sent;
	int                 frames_sent;

	sobel_gradient_direction_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready), .magnitude(magnitude),
		.direction_code(direction_code), .last_of_frame(last_of_frame),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sobel_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready), .magnitude(magnitude),
		.direction_code(direction_code), .last_of_frame(last_of_frame),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 800000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// receiver: short random stalls, occasional long ones, long hold on request
	initial begin
		int stall;
		out_ready = 1'b0;
		hold_seen = 0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				stall = 400;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				case ($urandom_range(0, 99))
					0, 1, 2, 3, 4, 5, 6, 7: stall = $urandom_range(1, 3);
					8: stall = $urandom_range(20, 80);
					default: stall = 0;
				endcase
			end
		end
	end

	task automatic send_pixel(logic [PixW-1:0] p);
		int gap;
		gap = 0;
		if (busy_gaps != 0) begin
			case ($urandom_range(0, 99))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19:
					gap = $urandom_range(1, 3);
				20: gap = $urandom_range(20, 60);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= p;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		pixels_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [HeightW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_size(logic [HeightW-1:0] w, logic [HeightW-1:0] h);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		@(posedge clk);
	endtask

	// style: 0 noise, 1 black/white, 2 smooth ramp with small noise
	task automatic send_frame(int w, int h, int style);
		int base;
		base = $urandom_range(0, 255);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				case (style)
					0: send_pixel(PixW'($urandom_range(0, 255)));
					1: send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00);
					default: send_pixel(PixW'(base + 3*r + 2*c + $urandom_range(0, 4)));
				endcase
		frames_sent++;
	endtask

	task automatic send_square(logic [PixW-1:0] img[9]);
		foreach (img[i]) send_pixel(img[i]);
		frames_sent++;
	endtask

	initial begin
		int rw, rh;
		in_valid = 1'b0;
		pixel_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		hold_req = 0;
		busy_gaps = 0;
		pixels_sent = 0;
		frames_sent = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frames: flat, edges in each direction, strongest gradient
		set_size(3, 3);
		send_square('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
		send_square('{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255});
		send_square('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
		send_square('{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0});
		send_square('{8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
		send_square('{8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd0, 8'd255});
		busy_gaps = 1;

		// undersized registers act as 3
		set_size(0, 0);
		send_frame(3, 3, 1);
		set_size(2, 2);
		send_frame(3, 3, 0);

		// oversized width: part of a long row, then a narrow width closes it
		set_size(2047, 3);
		repeat (60) send_pixel(PixW'($urandom_range(0, 255)));
		drain();
		write_reg(REG_WIDTH, 4);
		repeat (9) send_pixel(PixW'($urandom_range(0, 255)));
		frames_sent++;

		// tallest height, then shorten it at a row boundary to close the frame
		set_size(3, 4095);
		send_frame(3, 5, 0);
		drain();
		write_reg(REG_HEIGHT, 3);
		send_frame(3, 1, 0);

		// long receiver hold while pixels keep coming
		set_size(6, 5);
		hold_req++;
		send_frame(6, 5, 0);

		while (pixels_sent < 700) begin
			case ($urandom_range(0, 9))
				0: rw = $urandom_range(0, 2);
				1: rw = $urandom_range(13, 40);
				default: rw = $urandom_range(3, 12);
			endcase
			rh = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8);
			set_size(HeightW'(rw), HeightW'(rh));
			busy_gaps = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(1, 2))
				send_frame(rw < 3 ? 3 : rw, rh < 3 ? 3 : rh, $urandom_range(0, 2));
		end
		drain();

		$display("covered %0d pixels in %0d frames, widths 3 to 40 and an oversized one,",
			pixels_sent, frames_sent);
		$display("heights 3 to 4095, random sender gaps, receiver stalls and one long hold");
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
